### rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, fixed-point constants and helpers for the escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Fixed-point format of every complex value: signed, 32 bits, 27 fractional.
  localparam int FRAC_BITS = 27;
  localparam int COORD_W   = 32;
  localparam int PIXEL_W   = 14;
  localparam int COUNT_W   = 10;
  localparam int PROD_W    = 2 * COORD_W;

  // Side of the square image in pixels. It is a power of two, so the mapping
  // 4 * v / IMAGE_SIZE in the fixed-point format is a left shift of v.
  localparam int IMAGE_SIZE = 16384;
  localparam int MAP_SHIFT  = FRAC_BITS + 2 - $clog2(IMAGE_SIZE);

  // Depth of the queue between the mapping front and the iteration back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(512);

  // 2.0 in the fixed-point format, and 4.0 in the squared (product) scale.
  localparam logic signed [PROD_W-1:0] TWO     = PROD_W'(1) <<< (FRAC_BITS + 1);
  localparam logic [PROD_W-1:0]        FOUR_SQ = PROD_W'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [PROD_W-1:0] COORD_MAX = PROD_W'(64'sh7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] COORD_MIN = -PROD_W'(64'sh8000_0000);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t c_re;
    coord_t c_im;
  } c_pair_t;

  // Saturate a wide signed value to the signed 32-bit coordinate range.
  function automatic coord_t sat32(input logic signed [PROD_W-1:0] v);
    coord_t r;
    if (v > COORD_MAX) begin
      r = coord_t'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      r = coord_t'(COORD_MIN);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Accepts a pixel and maps it onto the complex plane with a shift, then
// pushes the point c into the queue.
// ----------------------------------------------------------------------------
module mbe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbe_pkg::PIXEL_W-1:0]   pixel_x,
  input  logic [mbe_pkg::PIXEL_W-1:0]   pixel_y,
  output logic                          busy,
  input  logic                          q_full,
  output logic                          q_push,
  output mbe_pkg::c_pair_t              q_wdata
);

  localparam int PW = mbe_pkg::PROD_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PUSH = 1'b1;

  logic                 state;
  mbe_pkg::c_pair_t     point;

  logic signed [PW-1:0] scaled_x;
  logic signed [PW-1:0] scaled_y;

  // The image side is a power of two, so the mapping divide is a left shift.
  always_comb begin
    scaled_x = $signed(PW'(pixel_x) << mbe_pkg::MAP_SHIFT);
    scaled_y = $signed(PW'(pixel_y) << mbe_pkg::MAP_SHIFT);
  end

  assign busy    = (state != ST_IDLE);
  assign q_push  = (state == ST_PUSH) && !q_full;
  assign q_wdata = point;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      point.c_re <= mbe_pkg::sat32(scaled_x - mbe_pkg::TWO);
      point.c_im <= mbe_pkg::sat32(mbe_pkg::TWO - scaled_y);
    end
  end

endmodule

### rtl/core/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Short first-in first-out queue of mapped points between front and back.
// ----------------------------------------------------------------------------
module mbe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbe_pkg::c_pair_t wdata,
  output logic             full,
  input  logic             pop,
  output mbe_pkg::c_pair_t rdata,
  output logic             empty
);

  localparam int DEPTH = mbe_pkg::QUEUE_DEPTH;

  mbe_pkg::c_pair_t               entries [DEPTH];
  logic [mbe_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mbe_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mbe_pkg::QCNT_W-1:0]     count;

  assign full  = (count == mbe_pkg::QCNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mbe_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mbe_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + mbe_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - mbe_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/core/mbe_back.sv
// ----------------------------------------------------------------------------
// mbe_back
// Iterates z = z*z + c for one point at a time: a squaring state, then an
// escape test and update state, and drives the registered result.
// ----------------------------------------------------------------------------
module mbe_back #(
  parameter int ITER_LIMIT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mbe_pkg::COUNT_W-1:0]   max_iterations,
  input  logic                          q_empty,
  input  mbe_pkg::c_pair_t              q_rdata,
  output logic                          q_pop,
  output logic                          done,
  output logic [mbe_pkg::COUNT_W-1:0]   escape_count,
  output logic                          in_set
);

  localparam int CW = mbe_pkg::COUNT_W;
  localparam int PW = mbe_pkg::PROD_W;
  localparam int F  = mbe_pkg::FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;

  logic [1:0]              state;
  mbe_pkg::coord_t         c_re;
  mbe_pkg::coord_t         c_im;
  mbe_pkg::coord_t         re;
  mbe_pkg::coord_t         im;
  logic signed [PW-1:0]    rr;
  logic signed [PW-1:0]    ii;
  logic signed [PW-1:0]    ri;
  logic [CW-1:0]           iter;
  logic [CW-1:0]           limit;

  logic [CW-1:0]           eff_limit;
  logic [PW-1:0]           mag_sq;
  logic                    escaped;
  logic                    last_iter;
  logic signed [PW-1:0]    diff;
  mbe_pkg::coord_t         nre;
  mbe_pkg::coord_t         nim;
  logic                    done_next;

  always_comb begin
    eff_limit = (32'(max_iterations) > ITER_LIMIT) ? CW'(ITER_LIMIT) : max_iterations;
    mag_sq    = $unsigned(rr) + $unsigned(ii);
    escaped   = mag_sq > mbe_pkg::FOUR_SQ;
    last_iter = (iter == limit);
    diff      = rr - ii;
    // Doubling re*im before the floor shift equals shifting by one bit less.
    nre = mbe_pkg::sat32((diff >>> F) + $signed({{(PW - 32){c_re[31]}}, c_re}));
    nim = mbe_pkg::sat32((ri >>> (F - 1)) + $signed({{(PW - 32){c_im[31]}}, c_im}));
    done_next = ((state == ST_IDLE) && !q_empty && (eff_limit == '0)) ||
                ((state == ST_CHK) && (escaped || last_iter));
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty && (eff_limit != '0)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (escaped || last_iter) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          c_re         <= q_rdata.c_re;
          c_im         <= q_rdata.c_im;
          re           <= q_rdata.c_re;
          im           <= q_rdata.c_im;
          iter         <= CW'(1);
          limit        <= eff_limit;
          escape_count <= '0;
          in_set       <= 1'b1;
        end
      end
      ST_MUL: begin
        rr <= PW'(re) * PW'(re);
        ii <= PW'(im) * PW'(im);
        ri <= PW'(re) * PW'(im);
      end
      ST_CHK: begin
        if (escaped) begin
          escape_count <= iter;
          in_set       <= 1'b0;
        end else begin
          re   <= nre;
          im   <= nim;
          iter <= iter + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time unit: maps a pixel onto [-2, 2] x [-2, 2] and counts the
// iterations of z = z*z + c until |z| exceeds 2 or the budget runs out.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Handshake
//   -------   ---------------------------------   ------------------------------
//   command   start, pixel_x, pixel_y, busy       word taken when start && !busy
//   result    done, escape_count, in_set          word valid for the one done cycle
//   config    cfg_we, cfg_wdata                   max_iterations written on cfg_we
//
// The image side is a power of two, so the front maps a pixel with a shift
// in the cycle that takes it and offers the point to the queue on the next
// cycle; busy is high for that cycle and for as long as the queue is full.
// The back takes a point from the queue and then, for each iteration, squares
// z and then tests and updates it; it keeps that point until it escapes or
// reaches its limit, and only then takes the next one. The two-entry queue
// lets the front map the next pixels while the back iterates. Reset is
// synchronous and active high; it empties the queue, idles both parts and
// loads max_iterations with 512. The receiver cannot stall: a result word
// is shown for exactly one cycle.
//
module mandelbrot_escape_time #(
  parameter int ITER_LIMIT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbe_pkg::PIXEL_W-1:0]   pixel_x,
  input  logic [mbe_pkg::PIXEL_W-1:0]   pixel_y,
  output logic                          busy,
  output logic                          done,
  output logic [mbe_pkg::COUNT_W-1:0]   escape_count,
  output logic                          in_set,
  input  logic                          cfg_we,
  input  logic [mbe_pkg::COUNT_W-1:0]   cfg_wdata
);

  // Iteration budget; the back clamps it to ITER_LIMIT when it starts a point.
  logic [mbe_pkg::COUNT_W-1:0] max_iterations;

  mbe_pkg::c_pair_t q_wdata;
  mbe_pkg::c_pair_t q_rdata;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mbe_pkg::MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iterations <= cfg_wdata;
    end
  end

  // Front: takes the command word and computes c with a shift.
  mbe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // Queue of mapped points; order is kept, so results leave in command order.
  mbe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back: runs the iteration and registers the result word.
  mbe_back #(
    .ITER_LIMIT(ITER_LIMIT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .done           (done),
    .escape_count   (escape_count),
    .in_set         (in_set)
  );

endmodule
